@@ rtl/scs_pkg.sv @@
package scs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int LATENCY         = 5;

    typedef enum logic [1:0] {
        MODE_POINT  = 2'd0,
        MODE_SEG    = 2'd1,
        MODE_SPHERE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1,
        REG_CENTRE_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic  vld;
        mode_t mode;
    } ctl_t;

endpackage

@@ rtl/scs_cfg.sv @@
module scs_cfg #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [scs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data,
    output logic signed [COORD_WIDTH-1:0]         centre_x,
    output logic signed [COORD_WIDTH-1:0]         centre_y,
    output logic signed [COORD_WIDTH-1:0]         centre_z,
    output logic [COORD_WIDTH-2:0]                radius
);
    import scs_pkg::*;

    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg, cz_reg;
    logic [COORD_WIDTH-2:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTRE_X: cx_reg  <= cfg_data;
                REG_CENTRE_Y: cy_reg  <= cfg_data;
                REG_CENTRE_Z: cz_reg  <= cfg_data;
                REG_RADIUS:   rad_reg <= cfg_data[COORD_WIDTH-2:0];
                default:      ;
            endcase
        end
    end

    assign centre_x = cx_reg;
    assign centre_y = cy_reg;
    assign centre_z = cz_reg;
    assign radius   = rad_reg;

endmodule

@@ rtl/scs_front.sv @@
module scs_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scs_pkg::ctl_t                         in_ctl,
    input  logic signed [COORD_WIDTH-1:0]         first_x,
    input  logic signed [COORD_WIDTH-1:0]         first_y,
    input  logic signed [COORD_WIDTH-1:0]         first_z,
    input  logic signed [COORD_WIDTH-1:0]         second_x,
    input  logic signed [COORD_WIDTH-1:0]         second_y,
    input  logic signed [COORD_WIDTH-1:0]         second_z,
    input  logic [COORD_WIDTH-2:0]                other_radius,
    input  logic signed [COORD_WIDTH-1:0]         centre_x,
    input  logic signed [COORD_WIDTH-1:0]         centre_y,
    input  logic signed [COORD_WIDTH-1:0]         centre_z,
    input  logic [COORD_WIDTH-2:0]                radius,
    output scs_pkg::ctl_t                         out_ctl,
    output logic signed [2*COORD_WIDTH+1:0]       mm_x,
    output logic signed [2*COORD_WIDTH+1:0]       mm_y,
    output logic signed [2*COORD_WIDTH+1:0]       mm_z,
    output logic signed [2*COORD_WIDTH+1:0]       md_x,
    output logic signed [2*COORD_WIDTH+1:0]       md_y,
    output logic signed [2*COORD_WIDTH+1:0]       md_z,
    output logic signed [2*COORD_WIDTH+1:0]       dd_x,
    output logic signed [2*COORD_WIDTH+1:0]       dd_y,
    output logic signed [2*COORD_WIDTH+1:0]       dd_z,
    output logic [2*COORD_WIDTH-3:0]              rr,
    output logic [2*COORD_WIDTH-1:0]              rs2
);
    import scs_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    // stage 1: offsets
    ctl_t                  ctl1_reg;
    logic signed [DW-1:0]  m_x_reg, m_y_reg, m_z_reg;
    logic signed [DW-1:0]  d_x_reg, d_y_reg, d_z_reg;
    logic [COORD_WIDTH-2:0] r_reg;
    logic [COORD_WIDTH-1:0] rs_reg;

    // stage 2: products
    ctl_t                  ctl2_reg;
    logic signed [PW-1:0]  mm_x_reg, mm_y_reg, mm_z_reg;
    logic signed [PW-1:0]  md_x_reg, md_y_reg, md_z_reg;
    logic signed [PW-1:0]  dd_x_reg, dd_y_reg, dd_z_reg;
    logic [2*COORD_WIDTH-3:0] rr_reg;
    logic [2*COORD_WIDTH-1:0] rs2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_x_reg  <= DW'(first_x) - DW'(centre_x);
        m_y_reg  <= DW'(first_y) - DW'(centre_y);
        m_z_reg  <= DW'(first_z) - DW'(centre_z);
        d_x_reg  <= DW'(second_x) - DW'(first_x);
        d_y_reg  <= DW'(second_y) - DW'(first_y);
        d_z_reg  <= DW'(second_z) - DW'(first_z);
        r_reg    <= radius;
        rs_reg   <= COORD_WIDTH'(radius) + COORD_WIDTH'(other_radius);

        mm_x_reg <= m_x_reg * m_x_reg;
        mm_y_reg <= m_y_reg * m_y_reg;
        mm_z_reg <= m_z_reg * m_z_reg;
        md_x_reg <= m_x_reg * d_x_reg;
        md_y_reg <= m_y_reg * d_y_reg;
        md_z_reg <= m_z_reg * d_z_reg;
        dd_x_reg <= d_x_reg * d_x_reg;
        dd_y_reg <= d_y_reg * d_y_reg;
        dd_z_reg <= d_z_reg * d_z_reg;
        rr_reg   <= r_reg * r_reg;
        rs2_reg  <= rs_reg * rs_reg;
    end

    assign out_ctl = ctl2_reg;
    assign mm_x = mm_x_reg;
    assign mm_y = mm_y_reg;
    assign mm_z = mm_z_reg;
    assign md_x = md_x_reg;
    assign md_y = md_y_reg;
    assign md_z = md_z_reg;
    assign dd_x = dd_x_reg;
    assign dd_y = dd_y_reg;
    assign dd_z = dd_z_reg;
    assign rr   = rr_reg;
    assign rs2  = rs2_reg;

endmodule

@@ rtl/scs_back.sv @@
module scs_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scs_pkg::ctl_t                         in_ctl,
    input  logic signed [2*COORD_WIDTH+1:0]       mm_x,
    input  logic signed [2*COORD_WIDTH+1:0]       mm_y,
    input  logic signed [2*COORD_WIDTH+1:0]       mm_z,
    input  logic signed [2*COORD_WIDTH+1:0]       md_x,
    input  logic signed [2*COORD_WIDTH+1:0]       md_y,
    input  logic signed [2*COORD_WIDTH+1:0]       md_z,
    input  logic signed [2*COORD_WIDTH+1:0]       dd_x,
    input  logic signed [2*COORD_WIDTH+1:0]       dd_y,
    input  logic signed [2*COORD_WIDTH+1:0]       dd_z,
    input  logic [2*COORD_WIDTH-3:0]              rr,
    input  logic [2*COORD_WIDTH-1:0]              rs2,
    output logic                                  done,
    output logic                                  hit
);
    import scs_pkg::*;

    localparam int PW  = 2 * COORD_WIDTH + 2;
    localparam int SW  = PW + 2;            // dot products
    localparam int CW  = SW + 1;            // dot minus square
    localparam int GW  = CW + 2;
    localparam int K   = CW / 2;
    localparam int HW  = CW - K;
    localparam int TW  = 2 * CW + 4;

    // stage 3: dot products
    ctl_t                 ctl3_reg;
    logic signed [CW-1:0] a_reg, h_reg, c_reg, q_reg;
    logic signed [SW-1:0] mm_sum;

    always_comb
    begin
        mm_sum = SW'(mm_x) + SW'(mm_y) + SW'(mm_z);
    end

    // stage 4: flags and partial products of h*h - a*c
    ctl_t                    ctl4_reg;
    logic                    a_zero_reg, c_neg_reg, c_zero_reg, g1_neg_reg, g1_zero_reg;
    logic                    h_neg_reg, ah_neg_reg, q_pos_reg;
    logic signed [TW-1:0]    t2_reg, t1_reg, t0_reg;

    logic signed [GW-1:0]    g1;
    logic signed [CW:0]      ah;
    logic signed [HW-1:0]    h_hi, a_hi, c_hi;
    logic signed [K:0]       h_lo, a_lo, c_lo;
    logic signed [2*HW-1:0]  p_hh, p_ac_hh;
    logic signed [HW+K:0]    p_hl, p_ac_hl, p_ac_lh;
    logic signed [2*K+1:0]   p_ll, p_ac_ll;

    always_comb
    begin
        g1   = GW'(a_reg) + (GW'(h_reg) <<< 1) + GW'(c_reg);
        ah   = (CW+1)'(a_reg) + (CW+1)'(h_reg);
        h_hi = h_reg[CW-1:K];
        a_hi = a_reg[CW-1:K];
        c_hi = c_reg[CW-1:K];
        h_lo = {1'b0, h_reg[K-1:0]};
        a_lo = {1'b0, a_reg[K-1:0]};
        c_lo = {1'b0, c_reg[K-1:0]};
        p_hh    = h_hi * h_hi;
        p_ac_hh = a_hi * c_hi;
        p_hl    = (HW+K+1)'(h_hi) * (HW+K+1)'(h_lo);
        p_ac_hl = (HW+K+1)'(a_hi) * (HW+K+1)'(c_lo);
        p_ac_lh = (HW+K+1)'(a_lo) * (HW+K+1)'(c_hi);
        p_ll    = h_lo * h_lo;
        p_ac_ll = a_lo * c_lo;
    end

    // stage 5: decision
    logic                 hit_reg, done_reg;
    logic signed [TW-1:0] disc;
    logic                 hit_next;

    always_comb
    begin
        disc = (t2_reg <<< (2 * K)) + (t1_reg <<< K) + t0_reg;
        hit_next = 1'b0;
        case (ctl4_reg.mode)
            MODE_POINT:  hit_next = c_neg_reg | c_zero_reg;
            MODE_SPHERE: hit_next = !q_pos_reg;
            MODE_SEG:
            begin
                if (a_zero_reg)
                    hit_next = c_neg_reg | c_zero_reg;
                else if (c_zero_reg)
                    hit_next = 1'b1;
                else if (c_neg_reg)
                    hit_next = !g1_neg_reg;
                else if (g1_neg_reg | g1_zero_reg)
                    hit_next = 1'b1;
                else if (!h_neg_reg)
                    hit_next = 1'b0;
                else if (ah_neg_reg)
                    hit_next = 1'b0;
                else
                    hit_next = !disc[TW-1];
            end
            default:     hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl3_reg <= in_ctl;
            ctl4_reg <= ctl3_reg;
            done_reg <= ctl4_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= CW'(SW'(dd_x) + SW'(dd_y) + SW'(dd_z));
        h_reg <= CW'(SW'(md_x) + SW'(md_y) + SW'(md_z));
        c_reg <= CW'(mm_sum) - $signed({{(CW-(2*COORD_WIDTH-2)){1'b0}}, rr});
        q_reg <= CW'(mm_sum) - $signed({{(CW-2*COORD_WIDTH){1'b0}}, rs2});

        a_zero_reg  <= (a_reg == '0);
        c_neg_reg   <= c_reg[CW-1];
        c_zero_reg  <= (c_reg == '0);
        g1_neg_reg  <= g1[GW-1];
        g1_zero_reg <= (g1 == '0);
        h_neg_reg   <= h_reg[CW-1];
        ah_neg_reg  <= ah[CW];
        q_pos_reg   <= !q_reg[CW-1] && (q_reg != '0);
        t2_reg <= TW'(p_hh) - TW'(p_ac_hh);
        t1_reg <= (TW'(p_hl) <<< 1) - TW'(p_ac_hl) - TW'(p_ac_lh);
        t0_reg <= TW'(p_ll) - TW'(p_ac_ll);

        hit_reg <= hit_next;
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

@@ rtl/sphere_collision_tests_unit.sv @@
// Sphere collision test unit.
// The sphere (centre_x/y/z, radius) is loaded through the configuration port:
// cfg_write with cfg_index and cfg_data writes one register at the clock edge.
// Write it only while no transaction is in flight.
// A query transaction is accepted at each edge where start is high and busy
// is low; busy is always low, so a new query can enter on every cycle.
// mode selects the test: point inside, segment, sphere against sphere.
// The answer appears on hit with done high for one cycle, registered at the
// end of the pipeline; one result per query, in order.
// Throughput is one query per cycle, set by the five-stage pipeline
// (offsets, products, dot sums, split discriminant products, decision).
// The receiver cannot stall; it must take hit on the cycle done is high.
// Reset clears all configuration registers to zero and drops every query
// in flight; no done is produced for them.
module sphere_collision_tests_unit #(
    parameter int COORD_WIDTH = scs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [scs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            mode,
    input  logic signed [COORD_WIDTH-1:0]         first_x,
    input  logic signed [COORD_WIDTH-1:0]         first_y,
    input  logic signed [COORD_WIDTH-1:0]         first_z,
    input  logic signed [COORD_WIDTH-1:0]         second_x,
    input  logic signed [COORD_WIDTH-1:0]         second_y,
    input  logic signed [COORD_WIDTH-1:0]         second_z,
    input  logic [COORD_WIDTH-2:0]                other_radius,
    output logic                                  done,
    output logic                                  hit
);
    import scs_pkg::*;

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0] centre_x, centre_y, centre_z;
    logic [COORD_WIDTH-2:0]        radius;
    ctl_t                          in_ctl, mid_ctl;
    logic signed [PW-1:0]          mm_x, mm_y, mm_z, md_x, md_y, md_z, dd_x, dd_y, dd_z;
    logic [2*COORD_WIDTH-3:0]      rr;
    logic [2*COORD_WIDTH-1:0]      rs2;

    assign busy        = 1'b0;
    assign in_ctl.vld  = start & ~busy;
    assign in_ctl.mode = mode_t'(mode);

    scs_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
        .radius(radius)
    );

    scs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ctl(in_ctl),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .other_radius(other_radius),
        .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
        .radius(radius),
        .out_ctl(mid_ctl),
        .mm_x(mm_x), .mm_y(mm_y), .mm_z(mm_z),
        .md_x(md_x), .md_y(md_y), .md_z(md_z),
        .dd_x(dd_x), .dd_y(dd_y), .dd_z(dd_z),
        .rr(rr), .rs2(rs2)
    );

    scs_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .in_ctl(mid_ctl),
        .mm_x(mm_x), .mm_y(mm_y), .mm_z(mm_z),
        .md_x(md_x), .md_y(md_y), .md_z(md_z),
        .dd_x(dd_x), .dd_y(dd_y), .dd_z(dd_z),
        .rr(rr), .rs2(rs2),
        .done(done), .hit(hit)
    );

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("transaction result missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##5 !done)
        else $error("result without transaction");

    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_NONE) |-> ##5 !hit)
        else $error("unused mode reported hit");

endmodule

@@ bench/tb_sphere_collision_tests_unit.sv @@
`timescale 1ns / 100ps

module tb_sphere_collision_tests_unit;
    import scs_pkg::*;

    localparam int CW          = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 300;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] fz;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sz;
        logic [CW-2:0]        orad;
    } query_t;

    class hit_scoreboard;
        logic signed [CW-1:0] cx, cy, cz;
        logic [CW-2:0]        rad;
        bit                   hit_q[$];
        int                   fails;

        function new();
            cx = '0; cy = '0; cz = '0; rad = '0;
            fails = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CW-1:0] d);
            case (idx)
                REG_CENTRE_X: cx = d;
                REG_CENTRE_Y: cy = d;
                REG_CENTRE_Z: cz = d;
                REG_RADIUS:   rad = d[CW-2:0];
            endcase
        endfunction

        function bit predict_hit(query_t q);
            wide_t r, rr, rs, mx, my, mz, dx, dy, dz, a, h, c, g1;
            r  = wide_t'({1'b0, rad});
            rr = r * r;
            mx = wide_t'(q.fx) - wide_t'(cx);
            my = wide_t'(q.fy) - wide_t'(cy);
            mz = wide_t'(q.fz) - wide_t'(cz);
            case (mode_t'(q.mode))
                MODE_POINT:
                    return (mx * mx + my * my + mz * mz - rr) <= 0;
                MODE_SPHERE: begin
                    rs = r + wide_t'({1'b0, q.orad});
                    return (mx * mx + my * my + mz * mz - rs * rs) <= 0;
                end
                MODE_SEG: begin
                    dx = wide_t'(q.sx) - wide_t'(q.fx);
                    dy = wide_t'(q.sy) - wide_t'(q.fy);
                    dz = wide_t'(q.sz) - wide_t'(q.fz);
                    a  = dx * dx + dy * dy + dz * dz;
                    h  = mx * dx + my * dy + mz * dz;
                    c  = mx * mx + my * my + mz * mz - rr;
                    if (a == 0)
                        return c <= 0;
                    g1 = a + h + h + c;
                    if (c == 0)
                        return 1'b1;
                    if (c < 0)
                        return g1 >= 0;
                    if (g1 <= 0)
                        return 1'b1;
                    if (h >= 0)
                        return 1'b0;
                    if (a + h < 0)
                        return 1'b0;
                    return (h * h - a * c) >= 0;
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_query(query_t q);
            hit_q.push_back(predict_hit(q));
        endfunction

        function void check_result(bit got);
            bit want;
            if (hit_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result transaction: hit=%0b", got);
                return;
            end
            want = hit_q.pop_front();
            if (want !== got) begin
                fails++;
                if (fails <= 10)
                    $display("hit mismatch: expected %0b actual %0b", want, got);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [CW-1:0] cfg_data;
    logic          start;
    logic          busy;
    logic          done;
    logic          hit;
    query_t        cur;
    hit_scoreboard sb;
    int            idle_cycles;
    bit            no_idle;

    sphere_collision_tests_unit #(.COORD_WIDTH(CW)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .mode         (cur.mode),
        .first_x      (cur.fx),
        .first_y      (cur.fy),
        .first_z      (cur.fz),
        .second_x     (cur.sx),
        .second_y     (cur.sy),
        .second_z     (cur.sz),
        .other_radius (cur.orad),
        .done         (done),
        .hit          (hit)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_query(cur);
            if (done)
                sb.check_result(hit);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sphere_collision_tests_unit verification failed");
                $finish;
            end
        end
    end

    function automatic query_t mk(mode_t m, logic [CW-1:0] fx, logic [CW-1:0] fy,
                                  logic [CW-1:0] fz, logic [CW-1:0] sx,
                                  logic [CW-1:0] sy, logic [CW-1:0] sz,
                                  logic [CW-2:0] orad);
        query_t q;
        q.mode = m; q.fx = fx; q.fy = fy; q.fz = fz;
        q.sx = sx; q.sy = sy; q.sz = sz; q.orad = orad;
        return q;
    endfunction

    function automatic logic [CW-1:0] near(logic [CW-1:0] c);
        int off;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        off = $signed($urandom) >>> $urandom_range(0, 31);
        return c + off;
    endfunction

    task automatic send(query_t q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cur   <= q;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.hit_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        cfg_write <= 1'b0;
    endtask

    task automatic load_sphere(logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z, logic [CW-1:0] r);
        write_reg(REG_CENTRE_X, x);
        write_reg(REG_CENTRE_Y, y);
        write_reg(REG_CENTRE_Z, z);
        write_reg(REG_RADIUS, r);
    endtask

    task automatic run_directed();
        logic [CW-1:0] x, y, z, r;
        x = sb.cx; y = sb.cy; z = sb.cz; r = {1'b0, sb.rad};
        send(mk(MODE_POINT, x, y, z, 0, 0, 0, 0));
        send(mk(MODE_POINT, x + r, y, z, 0, 0, 0, 0));
        send(mk(MODE_POINT, x + r + 1, y, z, 0, 0, 0, 0));
        send(mk(MODE_POINT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
        send(mk(MODE_POINT, 32'h80000000, 32'h80000000, 32'h80000000,
                32'hffffffff, 32'hffffffff, 32'hffffffff, '1));
        send(mk(MODE_NONE, x, y, z, x, y, z, '1));
        send(mk(MODE_SEG, x, y, z, x, y, z, 0));
        send(mk(MODE_SEG, x + r + 1, y, z, x + r + 1, y, z, 0));
        send(mk(MODE_SEG, x, y, z, x + (r >> 1), y, z, 0));
        send(mk(MODE_SEG, x - 2 * r, y, z, x + 2 * r, y, z, 0));
        send(mk(MODE_SEG, x - r, y + r, z, x + r, y + r, z, 0));
        send(mk(MODE_SEG, x - r, y + r + 1, z, x + r, y + r + 1, z, 0));
        send(mk(MODE_SEG, x - 3 * r, y, z, x - 2 * r, y, z, 0));
        send(mk(MODE_SEG, x, y, z, x + 2 * r, y, z, 0));
        send(mk(MODE_SEG, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
        send(mk(MODE_SPHERE, x + r + 5, y, z, 0, 0, 0, 5));
        send(mk(MODE_SPHERE, x + r + 6, y, z, 0, 0, 0, 5));
        send(mk(MODE_SPHERE, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, '1));
        send(mk(MODE_SPHERE, x, y, z, 0, 0, 0, 0));
        drain();
    endtask

    task automatic run_random(int n);
        query_t q;
        int     k;
        for (k = 0; k < n; k++)
        begin
            if (k % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            q.mode = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            q.fx   = near(sb.cx);
            q.fy   = near(sb.cy);
            q.fz   = near(sb.cz);
            if ($urandom_range(0, 1))
            begin
                q.sx = near(sb.cx); q.sy = near(sb.cy); q.sz = near(sb.cz);
            end
            else
            begin
                q.sx = near(q.fx); q.sy = near(q.fy); q.sz = near(q.fz);
            end
            q.orad = (CW-1)'($urandom >> $urandom_range(1, 31));
            send(q);
            if (k == n / 2 && $urandom_range(0, 1))
                drain();
        end
        drain();
    endtask

    initial
    begin
        int p;
        sb          = new();
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        start       = 1'b0;
        cur         = '0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        load_sphere(32'h0001_8000, 32'hfffe_0000, 32'h0000_4000, 32'h0003_0000);
        run_directed();
        load_sphere(32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff);
        run_directed();
        run_random(RAND_ITEMS);
        load_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
        run_directed();
        run_random(RAND_ITEMS / 2);
        for (p = 0; p < RAND_PHASES; p++)
        begin
            load_sphere($urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(0, 16),
                        $urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(1, 31));
            run_random(RAND_ITEMS - 80);
        end

        drain();
        if (sb.fails == 0 && sb.hit_q.size() == 0)
            $display("sphere_collision_tests_unit verification clean");
        else
            $display("sphere_collision_tests_unit verification failed");
        $finish;
    end

endmodule

@@ sphere_collision_tests_unit.f @@
rtl/scs_pkg.sv
rtl/scs_cfg.sv
rtl/scs_front.sv
rtl/scs_back.sv
rtl/sphere_collision_tests_unit.sv
bench/tb_sphere_collision_tests_unit.sv
